FILE: rtl/shp3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shp3_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int POS_W      = 12;
	localparam int CFG_W      = 13;

	typedef logic [7:0]          pix_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [CFG_W-1:0]    cfg_t;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// one window column: rows R-2, R-1 and R
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	typedef struct packed {
		pos_t row;
		pos_t col;
		pix_t value;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/sharpen_3x3_plane_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------
// input     | in_valid / in_stall  | pixel_in
// output    | out_valid / out_stall| out_row, out_col, out_value, run_last
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A pixel is registered with its two line-buffer reads in stage 1, filtered
// there and its zero to three results land in the stage 2 result buffer.
// One pixel per cycle while out_stall is low; a pixel with more than one
// result holds the input while the buffer drains, one result a cycle.
// arst_n clears counters, window and valid state; line buffers hold
// whatever was last written.

module sharpen_3x3_plane_filter
	import shp3_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire pix_t  pixel_in,
	output logic       out_valid,
	input  wire logic  out_stall,
	output pos_t       out_row,
	output pos_t       out_col,
	output pix_t       out_value,
	output logic       run_last,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire logic  cfg_index,
	input  wire cfg_t  cfg_data
);

	cfg_t    frame_width_q, frame_height_q;
	cfg_t    w_eff, h_eff;

	pos_t    row_q, col_q;
	logic    col_wrap;
	logic [CFG_W-1:0] row_tmp, col_inc, row_inc;
	pos_t    row_eff, col_eff, row_n, col_n;

	pix_t    line_upper [MAX_WIDTH];
	pix_t    line_middle[MAX_WIDTH];

	logic    valid_s1;
	pix_t    pix_s1, up_s1, mid_s1;
	pos_t    row_s1, col_s1;

	column_t win_left_q, win_prev_q;
	column_t cur_col, left_col;
	pix_t    filt_a, filt_b;
	logic    do_filt, do_last, do_copy;
	result_t res_filt_a, res_filt_b, res_copy;
	result_t slot0, slot1, slot2;
	logic [1:0] cnt_n;

	result_t res_s2 [3];
	logic [1:0] cnt_s2, ptr_s2;

	logic    in_acc, out_acc, adv_s1, s2_free;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 13'd1920;
			frame_height_q <= 13'd1080;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < 13'd2) begin
			w_eff = 13'd2;
		end else if (frame_width_q > CFG_W'(MAX_WIDTH)) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < 13'd4) begin
			h_eff = 13'd4;
		end else if (frame_height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	// position of the incoming pixel and of the one after it
	always_comb begin
		col_wrap = {1'b0, col_q} >= w_eff;
		col_eff  = col_wrap ? '0 : col_q;
		row_tmp  = {1'b0, row_q} + CFG_W'(col_wrap);
		row_eff  = (row_tmp >= h_eff) ? '0 : row_tmp[POS_W-1:0];
		col_inc  = {1'b0, col_eff} + 13'd1;
		row_inc  = {1'b0, row_eff} + 13'd1;
		if (col_inc >= w_eff) begin
			col_n = '0;
			row_n = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
		end else begin
			col_n = col_inc[POS_W-1:0];
			row_n = row_eff;
		end
	end

	// handshakes
	assign out_acc  = out_valid && !out_stall;
	assign s2_free  = !out_valid || (out_acc && (ptr_s2 == cnt_s2 - 2'd1));
	assign adv_s1   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				row_q <= row_n;
				col_q <= col_n;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= pixel_in;
			row_s1 <= row_eff;
			col_s1 <= col_eff;
			up_s1  <= line_upper[col_eff[ADDR_W-1:0]];
			mid_s1 <= line_middle[col_eff[ADDR_W-1:0]];
		end
		// rotate the column down the line buffers as the pixel leaves stage 1
		if (adv_s1) begin
			line_upper[col_s1[ADDR_W-1:0]]  <= mid_s1;
			line_middle[col_s1[ADDR_W-1:0]] <= pix_s1;
		end
	end

	// stage 1: window and kernels
	assign cur_col  = '{top: up_s1, mid: mid_s1, bot: pix_s1};
	assign left_col = (col_s1 >= 12'd2) ? win_left_q : win_prev_q;

	shp3_kernel u_kernel_a (
		.l     (left_col),
		.m     (win_prev_q),
		.r     (cur_col),
		.value (filt_a)
	);

	// right edge: replicate the last column
	shp3_kernel u_kernel_b (
		.l     (win_prev_q),
		.m     (cur_col),
		.r     (cur_col),
		.value (filt_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q <= '0;
			win_prev_q <= '0;
		end else if (adv_s1) begin
			win_left_q <= win_prev_q;
			win_prev_q <= cur_col;
		end
	end

	always_comb begin
		do_filt = (row_s1 >= 12'd3) && (({1'b0, row_s1} + 13'd2) <= h_eff) &&
			(col_s1 != '0);
		do_last = do_filt && (({1'b0, col_s1} + 13'd1) == w_eff);
		do_copy = (row_s1 < 12'd2) || (({1'b0, row_s1} + 13'd2) >= h_eff);

		res_filt_a = '{row: row_s1 - 12'd1, col: col_s1 - 12'd1, value: filt_a};
		res_filt_b = '{row: row_s1 - 12'd1, col: col_s1, value: filt_b};
		res_copy   = '{row: row_s1, col: col_s1, value: pix_s1};

		slot0 = do_filt ? res_filt_a : res_copy;
		slot1 = do_last ? res_filt_b : res_copy;
		slot2 = res_copy;
		cnt_n = {1'b0, do_filt} + {1'b0, do_last} + {1'b0, do_copy};
	end

	// stage 2: result buffer, drained one result a cycle while out_stall is low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			ptr_s2 <= '0;
		end else if (adv_s1) begin
			cnt_s2 <= cnt_n;
			ptr_s2 <= '0;
		end else if (out_acc) begin
			ptr_s2 <= ptr_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2[0] <= slot0;
			res_s2[1] <= slot1;
			res_s2[2] <= slot2;
		end
	end

	always_comb begin
		result_t cur_res;
		case (ptr_s2)
			2'd0:    cur_res = res_s2[0];
			2'd1:    cur_res = res_s2[1];
			default: cur_res = res_s2[2];
		endcase
		out_valid = ptr_s2 < cnt_s2;
		out_row   = cur_res.row;
		out_col   = cur_res.col;
		out_value = cur_res.value;
		run_last  = ptr_s2 == (cnt_s2 - 2'd1);
	end

endmodule

`default_nettype wire

FILE: rtl/shp3_kernel.sv
`timescale 1ns / 1ps
`default_nettype none

module shp3_kernel
	import shp3_pkg::*;
(
	input  column_t l,
	input  column_t m,
	input  column_t r,
	output pix_t    value
);

	logic [9:0]         corners;
	logic [9:0]         edges;
	logic [12:0]        centre20;
	logic signed [13:0] v;
	logic signed [9:0]  delta;
	logic signed [10:0] t;

	always_comb begin
		corners  = 10'(l.top) + 10'(r.top) + 10'(l.bot) + 10'(r.bot);
		edges    = 10'(m.top) + 10'(l.mid) + 10'(r.mid) + 10'(m.bot);
		centre20 = {1'b0, m.mid, 4'b0000} + {3'b000, m.mid, 2'b00};
		v        = $signed(14'(corners) + {2'b00, edges, 2'b00} + 14'd8 - 14'(centre20));
		// floor division by 16
		delta    = 10'(v >>> 4);
		t        = $signed({3'b000, m.mid}) - 11'(delta);
		if (t < 0) begin
			value = 8'd0;
		end else if (t > 11'sd255) begin
			value = 8'd255;
		end else begin
			value = t[7:0];
		end
	end

endmodule

`default_nettype wire
